### hdl/kcs_pkg.sv
// Shared types and constants of the keyframe curve sampler.
// Holds request, slot, mode, status and register codes and the command/status structs.
// No dependencies; kcs_ctrl, kcs_dp and the top module import it.
package kcs_pkg;

   localparam int KCS_MAX_KEYS       = 64;
   localparam int KCS_MAX_COMPONENTS = 4;
   localparam int ENTRIES_PER_KEY    = 3;

   localparam logic [1:0] REQ_TIME   = 2'd0;
   localparam logic [1:0] REQ_ENTRY  = 2'd1;
   localparam logic [1:0] REQ_SAMPLE = 2'd2;

   localparam logic [1:0] SLOT_IN    = 2'd0;
   localparam logic [1:0] SLOT_VALUE = 2'd1;
   localparam logic [1:0] SLOT_OUT   = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ORDER    = 2'd1;
   localparam logic [1:0] STATUS_FEW_KEYS = 2'd2;

   localparam logic [1:0] CSR_INTERP_MODE     = 2'd0;
   localparam logic [1:0] CSR_KEY_COUNT       = 2'd1;
   localparam logic [1:0] CSR_COMPONENT_COUNT = 2'd2;

   typedef enum logic [1:0] {
      MODE_STEP   = 2'd0,
      MODE_LINEAR = 2'd1,
      MODE_CUBIC  = 2'd2
   } mode_type;

   typedef enum logic [5:0] {
      OP_NONE, OP_CAPTURE, OP_TRDPREV, OP_TWRITE, OP_EWRITE, OP_TRD0, OP_STAT,
      OP_TRDL, OP_TCHK, OP_PROBE, OP_CMP, OP_RDK, OP_RDK1, OP_TD, OP_WSET, OP_DIV,
      OP_T2, OP_T3, OP_H, OP_RDA, OP_CAPA, OP_RDB, OP_CAPB, OP_MLIN, OP_RDM0,
      OP_RDM1, OP_GETM1, OP_MH00, OP_MH01, OP_MH10, OP_MH11, OP_MQTD, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] err_code;
      logic       clamp_now;
      logic       clamp;
      logic       more_now;
      logic       need_div;
      logic       div_last;
      mode_type   mode;
      logic       last_comp;
      logic       out_free;
   } status_type;

endpackage

### hdl/kcs_if.sv
// Handshake channels of the keyframe curve sampler: request, result and register write.
// Each carries valid, ready and its payload; no dependencies.
interface kcs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [5:0]         key_index;
   logic [1:0]         comp_index;
   logic [1:0]         value_slot;
   logic [31:0]        time_word;
   logic signed [31:0] data_word;
   modport source (output valid, req_type, key_index, comp_index, value_slot, time_word,
                   data_word, input ready);
   modport sink (input valid, req_type, key_index, comp_index, value_slot, time_word,
                 data_word, output ready);
endinterface

interface kcs_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         out_component;
   logic signed [31:0] sample_value;
   logic               last_component;
   logic [1:0]         status;
   modport source (output valid, out_component, sample_value, last_component, status,
                   input ready);
   modport sink (input valid, out_component, sample_value, last_component, status,
                 output ready);
endinterface

interface kcs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [31:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

### hdl/kcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module kcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/kcs_ctrl.sv
// Sequencer of the keyframe curve sampler: one-hot state machine issuing datapath commands.
// Depends on kcs_pkg for the command and status structs.
module kcs_ctrl
   import kcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_type,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [31:0] {
      ST_IDLE  = 32'h0000_0001, ST_TPREV = 32'h0000_0002, ST_TWR   = 32'h0000_0004,
      ST_EWR   = 32'h0000_0008, ST_SDEC  = 32'h0000_0010, ST_STAT  = 32'h0000_0020,
      ST_TRDL  = 32'h0000_0040, ST_TCHK  = 32'h0000_0080, ST_PROBE = 32'h0000_0100,
      ST_CMP   = 32'h0000_0200, ST_RDK   = 32'h0000_0400, ST_RDK1  = 32'h0000_0800,
      ST_TD    = 32'h0000_1000, ST_WSET  = 32'h0000_2000, ST_DIV   = 32'h0000_4000,
      ST_T2    = 32'h0000_8000, ST_T3    = 32'h0001_0000, ST_H     = 32'h0002_0000,
      ST_RDA   = 32'h0004_0000, ST_CAPA  = 32'h0008_0000, ST_RDB   = 32'h0010_0000,
      ST_CAPB  = 32'h0020_0000, ST_MLIN  = 32'h0040_0000, ST_RDM0  = 32'h0080_0000,
      ST_RDM1  = 32'h0100_0000, ST_GETM1 = 32'h0200_0000, ST_MH00  = 32'h0400_0000,
      ST_MH01  = 32'h0800_0000, ST_MH10  = 32'h1000_0000, ST_MH11  = 32'h2000_0000,
      ST_MQTD  = 32'h4000_0000, ST_EMIT  = 32'h8000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_CAPTURE;
               case (req_type)
                  REQ_TIME:   state_in = ST_TPREV;
                  REQ_ENTRY:  state_in = ST_EWR;
                  REQ_SAMPLE: state_in = ST_SDEC;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_TPREV: begin
            cmd.op = OP_TRDPREV;
            state_in = ST_TWR;
         end
         ST_TWR: begin
            cmd.op = OP_TWRITE;
            state_in = ST_IDLE;
         end
         ST_EWR: begin
            cmd.op = OP_EWRITE;
            state_in = ST_IDLE;
         end
         ST_SDEC: begin
            cmd.op = OP_TRD0;
            state_in = (status.err_code != STATUS_OK) ? ST_STAT : ST_TRDL;
         end
         ST_STAT: begin
            if (status.out_free) begin
               cmd.op = OP_STAT;
               state_in = ST_IDLE;
            end
         end
         ST_TRDL: begin
            cmd.op = OP_TRDL;
            state_in = ST_TCHK;
         end
         ST_TCHK: begin
            cmd.op = OP_TCHK;
            if (status.clamp_now) begin
               state_in = ST_RDA;
            end else begin
               state_in = status.more_now ? ST_PROBE : ST_RDK;
            end
         end
         ST_PROBE: begin
            cmd.op = OP_PROBE;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.op = OP_CMP;
            state_in = status.more_now ? ST_PROBE : ST_RDK;
         end
         ST_RDK: begin
            cmd.op = OP_RDK;
            state_in = ST_RDK1;
         end
         ST_RDK1: begin
            cmd.op = OP_RDK1;
            state_in = ST_TD;
         end
         ST_TD: begin
            cmd.op = OP_TD;
            state_in = ST_WSET;
         end
         ST_WSET: begin
            cmd.op = OP_WSET;
            if (status.need_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = (status.mode == MODE_CUBIC) ? ST_T2 : ST_RDA;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (status.div_last) begin
               state_in = (status.mode == MODE_CUBIC) ? ST_T2 : ST_RDA;
            end
         end
         ST_T2: begin
            cmd.op = OP_T2;
            state_in = ST_T3;
         end
         ST_T3: begin
            cmd.op = OP_T3;
            state_in = ST_H;
         end
         ST_H: begin
            cmd.op = OP_H;
            state_in = ST_RDA;
         end
         ST_RDA: begin
            cmd.op = OP_RDA;
            if (status.clamp || status.mode == MODE_STEP) begin
               state_in = ST_CAPA;
            end else begin
               state_in = ST_RDB;
            end
         end
         ST_CAPA: begin
            cmd.op = OP_CAPA;
            state_in = ST_EMIT;
         end
         ST_RDB: begin
            cmd.op = OP_RDB;
            state_in = (status.mode == MODE_CUBIC) ? ST_RDM0 : ST_CAPB;
         end
         ST_CAPB: begin
            cmd.op = OP_CAPB;
            state_in = ST_MLIN;
         end
         ST_MLIN: begin
            cmd.op = OP_MLIN;
            state_in = ST_EMIT;
         end
         ST_RDM0: begin
            cmd.op = OP_RDM0;
            state_in = ST_RDM1;
         end
         ST_RDM1: begin
            cmd.op = OP_RDM1;
            state_in = ST_GETM1;
         end
         ST_GETM1: begin
            cmd.op = OP_GETM1;
            state_in = ST_MH00;
         end
         ST_MH00: begin
            cmd.op = OP_MH00;
            state_in = ST_MH01;
         end
         ST_MH01: begin
            cmd.op = OP_MH01;
            state_in = ST_MH10;
         end
         ST_MH10: begin
            cmd.op = OP_MH10;
            state_in = ST_MH11;
         end
         ST_MH11: begin
            cmd.op = OP_MH11;
            state_in = ST_MQTD;
         end
         ST_MQTD: begin
            cmd.op = OP_MQTD;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT;
               state_in = status.last_comp ? ST_IDLE : ST_RDA;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/kcs_dp.sv
// Datapath of the keyframe curve sampler: registers, key tables, search, divider,
// shared multiplier and result register. Depends on kcs_pkg and kcs_if, instantiates kcs_ram.
module kcs_dp
   import kcs_pkg::*;
#(
   parameter int MAX_KEYS       = KCS_MAX_KEYS,
   parameter int MAX_COMPONENTS = KCS_MAX_COMPONENTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [5:0]         key_index,
   input  logic [1:0]         comp_index,
   input  logic [1:0]         value_slot,
   input  logic [31:0]        time_word,
   input  logic signed [31:0] data_word,
   input  cmd_type            cmd,
   output status_type         status,
   kcs_rsp_if.source          rsp,
   kcs_csr_if.sink            csr
);

   localparam int TAW    = $clog2(MAX_KEYS);
   localparam int EDEPTH = MAX_KEYS * ENTRIES_PER_KEY * MAX_COMPONENTS;
   localparam int EAW    = $clog2(EDEPTH);
   localparam int NW     = $clog2(MAX_KEYS + 1);
   localparam int NC_LIM = (MAX_COMPONENTS < 4) ? MAX_COMPONENTS : 4;

   function automatic logic [EAW-1:0] ent_addr(input logic [31:0] k, input logic [1:0] s,
                                              input logic [1:0] c);
      logic [31:0] full;
      full = (k * 32'(ENTRIES_PER_KEY) + 32'(s)) * 32'(MAX_COMPONENTS) + 32'(c);
      return EAW'(full);
   endfunction

   // Configuration registers.
   logic [1:0] mode_cfg_ff;
   logic [6:0] kc_cfg_ff;
   logic [2:0] cc_cfg_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_cfg_ff <= 2'd1;
         kc_cfg_ff   <= 7'd1;
         cc_cfg_ff   <= 3'd1;
      end else if (csr.valid) begin
         case (csr.addr)
            CSR_INTERP_MODE:     mode_cfg_ff <= csr.wdata[1:0];
            CSR_KEY_COUNT:       kc_cfg_ff   <= csr.wdata[6:0];
            CSR_COMPONENT_COUNT: cc_cfg_ff   <= csr.wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // Request and per-sample registers.
   logic [5:0]         key_ff;
   logic [1:0]         comp_ff, slot_ff;
   logic [31:0]        t_ff;
   logic signed [31:0] data_ff;
   logic [NW-1:0]      n_ff;
   logic [2:0]         nc_ff;
   mode_type           mode_ff;
   logic               order_err_ff;
   logic [31:0]        t0_ff, tk_ff, tk1_ff, td_ff, rem_ff;
   logic [TAW-1:0]     lo_ff, hi_ff, mid_ff, k_ff;
   logic               clamp_ff;
   logic [15:0]        w_ff, t2_ff, t3_ff;
   logic [3:0]         div_cnt_ff;
   logic signed [19:0] h00_ff, h01_ff, h10_ff, h11_ff;
   logic signed [31:0] a_ff, b_ff, m0_ff, m1_ff;
   logic signed [66:0] acc_ff;
   logic signed [50:0] s1_ff;
   logic [1:0]         c_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_comp_ff, rsp_status_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_last_ff;

   // Memories.
   logic             t_wr_en, e_wr_en;
   logic [TAW-1:0]   t_rd_addr;
   logic [EAW-1:0]   e_rd_addr, e_wr_addr;
   logic [31:0]      t_rd;
   logic [31:0]      e_rd;

   logic key_ok, entry_ok;
   assign key_ok   = (32'(key_ff) < MAX_KEYS);
   assign entry_ok = key_ok && (32'(comp_ff) < MAX_COMPONENTS) && (slot_ff <= SLOT_OUT);
   assign t_wr_en  = (cmd.op == OP_TWRITE) && key_ok;
   assign e_wr_en  = (cmd.op == OP_EWRITE) && entry_ok;
   assign e_wr_addr = ent_addr(32'(key_ff), slot_ff, comp_ff);

   logic [TAW:0]   mid_sum;
   logic [TAW-1:0] mid;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[TAW:1];

   always_comb begin
      case (cmd.op)
         OP_TRDPREV: t_rd_addr = TAW'(32'(key_ff) - 32'd1);
         OP_TRDL:    t_rd_addr = TAW'(n_ff - NW'(1));
         OP_PROBE:   t_rd_addr = mid;
         OP_RDK:     t_rd_addr = lo_ff;
         OP_RDK1:    t_rd_addr = TAW'(32'(lo_ff) + 32'd1);
         default:    t_rd_addr = '0;
      endcase
      case (cmd.op)
         OP_RDB:  e_rd_addr = ent_addr(32'(k_ff) + 32'd1, SLOT_VALUE, c_ff);
         OP_RDM0: e_rd_addr = ent_addr(32'(k_ff), SLOT_OUT, c_ff);
         OP_RDM1: e_rd_addr = ent_addr(32'(k_ff) + 32'd1, SLOT_IN, c_ff);
         default: e_rd_addr = ent_addr(32'(k_ff), SLOT_VALUE, c_ff);
      endcase
   end

   kcs_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (TAW'(32'(key_ff))),
      .wr_data (t_ff),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd)
   );

   kcs_ram #(.WIDTH(32), .DEPTH(EDEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (data_ff),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd)
   );

   // Search and weight decisions.
   logic           clamp_lo, clamp_now;
   logic [TAW-1:0] lo_new, hi_new;
   logic [31:0]    td_now, diff_now;
   logic           w_zero, w_full;
   logic [32:0]    r2;
   logic           r2_ge;

   assign clamp_lo  = (n_ff == NW'(1)) || (t_ff <= t0_ff);
   assign clamp_now = clamp_lo || (t_ff >= t_rd);
   assign lo_new    = (t_ff < t_rd) ? lo_ff : mid_ff;
   assign hi_new    = (t_ff < t_rd) ? mid_ff : hi_ff;
   assign td_now    = (tk1_ff > tk_ff) ? (tk1_ff - tk_ff) : 32'd0;
   assign diff_now  = t_ff - tk_ff;
   assign w_zero    = (td_now == 32'd0) || (t_ff < tk_ff);
   assign w_full    = !w_zero && (diff_now >= td_now);
   assign r2        = {rem_ff, 1'b0};
   assign r2_ge     = (r2 >= {1'b0, td_ff});

   // Shared multiplier.
   logic signed [32:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [66:0] prod;

   always_comb begin
      case (cmd.op)
         OP_MLIN: begin
            mul_a = 33'(b_ff) - 33'(a_ff);
            mul_b = {18'b0, w_ff};
         end
         OP_MH00: begin
            mul_a = 33'(a_ff);
            mul_b = 34'(h00_ff);
         end
         OP_MH01: begin
            mul_a = 33'(b_ff);
            mul_b = 34'(h01_ff);
         end
         OP_MH10: begin
            mul_a = 33'(m0_ff);
            mul_b = 34'(h10_ff);
         end
         OP_MH11: begin
            mul_a = 33'(m1_ff);
            mul_b = 34'(h11_ff);
         end
         OP_MQTD: begin
            mul_a = 33'(signed'(acc_ff[47:16]));
            mul_b = {2'b0, td_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   // Final value of one component.
   logic signed [51:0] v_sum;
   logic signed [31:0] v_sat;
   logic               last_comp;

   always_comb begin
      if (clamp_ff || mode_ff == MODE_STEP) begin
         v_sum = 52'(a_ff);
      end else if (mode_ff == MODE_LINEAR) begin
         v_sum = 52'(a_ff) + 52'(signed'(acc_ff[66:16]));
      end else begin
         v_sum = 52'(s1_ff) + 52'(signed'(acc_ff[66:16]));
      end
      if (v_sum > 52'sd2147483647) begin
         v_sat = 32'sh7fff_ffff;
      end else if (v_sum < -52'sd2147483648) begin
         v_sat = 32'sh8000_0000;
      end else begin
         v_sat = v_sum[31:0];
      end
   end

   assign last_comp = ((3'(c_ff) + 3'd1) == nc_ff);

   logic [15:0]        t2_full_hi, t3_full_hi;
   logic [31:0]        sq, cu;
   logic signed [19:0] t2s, t3s, ws;
   assign sq         = w_ff * w_ff;
   assign cu         = t2_ff * w_ff;
   assign t2_full_hi = sq[31:16];
   assign t3_full_hi = cu[31:16];
   assign t2s        = signed'({4'b0, t2_ff});
   assign t3s        = signed'({4'b0, t3_ff});
   assign ws         = signed'({4'b0, w_ff});

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            key_ff  <= key_index;
            comp_ff <= comp_index;
            slot_ff <= value_slot;
            t_ff    <= time_word;
            data_ff <= data_word;
            if (kc_cfg_ff == 7'd0) begin
               n_ff <= NW'(1);
            end else if (32'(kc_cfg_ff) > MAX_KEYS) begin
               n_ff <= NW'(MAX_KEYS);
            end else begin
               n_ff <= NW'(kc_cfg_ff);
            end
            if (cc_cfg_ff == 3'd0) begin
               nc_ff <= 3'd1;
            end else if (32'(cc_cfg_ff) > NC_LIM) begin
               nc_ff <= 3'(NC_LIM);
            end else begin
               nc_ff <= cc_cfg_ff;
            end
            case (mode_cfg_ff)
               2'd0:    mode_ff <= MODE_STEP;
               2'd2:    mode_ff <= MODE_CUBIC;
               default: mode_ff <= MODE_LINEAR;
            endcase
         end
         OP_TRDL: t0_ff <= t_rd;
         OP_TCHK: begin
            clamp_ff <= clamp_now;
            k_ff     <= clamp_lo ? '0 : TAW'(n_ff - NW'(1));
            lo_ff    <= '0;
            hi_ff    <= TAW'(n_ff - NW'(1));
            c_ff     <= 2'd0;
         end
         OP_PROBE: mid_ff <= mid;
         OP_CMP: begin
            lo_ff <= lo_new;
            hi_ff <= hi_new;
         end
         OP_RDK1: begin
            tk_ff <= t_rd;
            k_ff  <= lo_ff;
         end
         OP_TD: tk1_ff <= t_rd;
         OP_WSET: begin
            td_ff      <= td_now;
            rem_ff     <= diff_now;
            div_cnt_ff <= 4'd0;
            c_ff       <= 2'd0;
            w_ff       <= w_full ? 16'hffff : 16'd0;
         end
         OP_DIV: begin
            // One restoring quotient bit per cycle.
            rem_ff     <= r2_ge ? 32'(r2 - {1'b0, td_ff}) : r2[31:0];
            w_ff       <= {w_ff[14:0], r2_ge};
            div_cnt_ff <= div_cnt_ff + 4'd1;
         end
         OP_T2: t2_ff <= t2_full_hi;
         OP_T3: t3_ff <= t3_full_hi;
         OP_H: begin
            h00_ff <= (t3s <<< 1) - (t2s + (t2s <<< 1)) + 20'sd65536;
            h01_ff <= (t2s + (t2s <<< 1)) - (t3s <<< 1);
            h10_ff <= t3s - (t2s <<< 1) + ws;
            h11_ff <= t3s - t2s;
         end
         OP_CAPA:  a_ff <= e_rd;
         OP_RDB:   a_ff <= e_rd;
         OP_CAPB:  b_ff <= e_rd;
         OP_RDM0:  b_ff <= e_rd;
         OP_RDM1:  m0_ff <= e_rd;
         OP_GETM1: m1_ff <= e_rd;
         OP_MLIN:  acc_ff <= prod;
         OP_MH00:  acc_ff <= prod;
         OP_MH01:  acc_ff <= acc_ff + prod;
         OP_MH10: begin
            s1_ff  <= signed'(acc_ff[66:16]);
            acc_ff <= prod;
         end
         OP_MH11:  acc_ff <= acc_ff + prod;
         OP_MQTD:  acc_ff <= prod;
         OP_EMIT:  c_ff <= c_ff + 2'd1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_err_ff <= 1'b0;
      end else if (t_wr_en) begin
         if (key_ff == 6'd0) begin
            order_err_ff <= 1'b0;
         end else if (t_ff <= t_rd) begin
            order_err_ff <= 1'b1;
         end
      end
   end

   // Result register: a finished result waits here while the sequencer moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT || cmd.op == OP_STAT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_comp_ff   <= c_ff;
         rsp_value_ff  <= v_sat;
         rsp_last_ff   <= last_comp;
         rsp_status_ff <= STATUS_OK;
      end else if (cmd.op == OP_STAT) begin
         rsp_comp_ff   <= 2'd0;
         rsp_value_ff  <= 32'sd0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= status.err_code;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_component  = rsp_comp_ff;
   assign rsp.sample_value   = rsp_value_ff;
   assign rsp.last_component = rsp_last_ff;
   assign rsp.status         = rsp_status_ff;

   always_comb begin
      if (mode_ff == MODE_CUBIC && n_ff < NW'(2)) begin
         status.err_code = STATUS_FEW_KEYS;
      end else if (order_err_ff) begin
         status.err_code = STATUS_ORDER;
      end else begin
         status.err_code = STATUS_OK;
      end
      status.clamp_now = clamp_now;
      status.clamp     = clamp_ff;
      if (cmd.op == OP_CMP) begin
         status.more_now = (hi_new - lo_new) > TAW'(1);
      end else begin
         status.more_now = (n_ff > NW'(2));
      end
      status.need_div  = !w_zero && !w_full;
      status.div_last  = (div_cnt_ff == 4'd15);
      status.mode      = mode_ff;
      status.last_comp = last_comp;
      status.out_free  = !rsp_valid_ff || rsp.ready;
   end

endmodule

### hdl/keyframe_curve_sampler_top.sv
// Keyframe curve sampler. An entry load writes the entry table; a time load first reads the
// previous key time for the order check. A sample finds the key pair by binary search, sets
// the weight with a restoring divider unless it is zero or full, builds the Hermite basis in
// cubic mode, then emits each component; a clamped sample skips search and divider. The
// single entry-memory read port and the one shared multiplier set the per-component cost.
// Reset is synchronous: control, order flag and registers return to their reset values;
// key tables are not cleared.
module keyframe_curve_sampler_top
   import kcs_pkg::*;
#(
   parameter int MAX_KEYS       = KCS_MAX_KEYS,
   parameter int MAX_COMPONENTS = KCS_MAX_COMPONENTS
) (
   input logic       clock,
   input logic       reset,
   kcs_req_if.sink   req_bus,
   kcs_rsp_if.source rsp_bus,
   kcs_csr_if.sink   csr_bus
);

   cmd_type    cmd;
   status_type status;

   kcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kcs_dp #(
      .MAX_KEYS       (MAX_KEYS),
      .MAX_COMPONENTS (MAX_COMPONENTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .key_index  (req_bus.key_index),
      .comp_index (req_bus.comp_index),
      .value_slot (req_bus.value_slot),
      .time_word  (req_bus.time_word),
      .data_word  (req_bus.data_word),
      .cmd        (cmd),
      .status     (status),
      .rsp        (rsp_bus),
      .csr        (csr_bus)
   );

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |=> rsp_bus.valid)
      else $error("component result not presented after emit");

   a_stat_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_STAT |=> rsp_bus.valid && rsp_bus.status != STATUS_OK)
      else $error("status result missing or carries ok status");

   a_stat_form: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != STATUS_OK |->
         rsp_bus.last_component && rsp_bus.sample_value == 0 && rsp_bus.out_component == 0)
      else $error("malformed status result");

endmodule

### bench/kcs_tb_if.sv
// Note: the block's channel interfaces live in hdl/kcs_if.sv; this bench reuses them.
// This file holds small shared types for the bench's pending request and expected result queues.
// Depends on kcs_pkg.
package kcs_tb_pkg;
   import kcs_pkg::*;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [5:0]         key_index;
      logic [1:0]         comp_index;
      logic [1:0]         value_slot;
      logic [31:0]        time_word;
      logic signed [31:0] data_word;
   } request_type;

   typedef struct packed {
      logic [1:0]         out_component;
      logic signed [31:0] sample_value;
      logic               last_component;
      logic [1:0]         status;
   } sample_type;
endpackage

### bench/tb.sv
// Bench for the keyframe curve sampler: directed and random loads and samples
// checked against an in-bench fixed point curve predictor. Depends on kcs_pkg,
// kcs_tb_pkg and the channel interfaces in hdl/kcs_if.sv.
module tb;
   import kcs_pkg::*;
   import kcs_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;

   kcs_req_if req_bus ();
   kcs_rsp_if rsp_bus ();
   kcs_csr_if csr_bus ();

   keyframe_curve_sampler_top u_top (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   // Predictor state.
   logic [31:0]        curve_times [KCS_MAX_KEYS];
   logic signed [31:0] curve_entries [KCS_MAX_KEYS*3*KCS_MAX_COMPONENTS];
   bit                 curve_order_bad;
   logic [1:0]         cfg_mode;
   logic [6:0]         cfg_keys;
   logic [2:0]         cfg_comps;

   request_type pending_requests[$];
   sample_type  expected_samples[$];

   int  send_idle_pct, recv_idle_pct;
   bit  recv_hold;
   int  mismatch_count;
   bit  req_taken;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint floor16(longint x);
      return x >>> 16;
   endfunction

   function automatic logic [31:0] saturate(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic longint entry_value(int key, logic [1:0] slot, int comp);
      return longint'(curve_entries[(key*3 + slot)*KCS_MAX_COMPONENTS + comp]);
   endfunction

   function automatic void push_result(int comp, logic [31:0] val, bit last,
                                       logic [1:0] st);
      sample_type s;
      s.out_component = comp[1:0];
      s.sample_value = val;
      s.last_component = last;
      s.status = st;
      expected_samples.push_back(s);
   endfunction

   // Updates the curve tables or predicts the results of one sample request.
   function automatic void predict_curve(request_type r);
      int n, nc, lo, hi, mid, k, kk;
      logic [1:0] mode;
      logic [31:0] tk, tk1, td, w;
      longint a, b, v, t2, t3, h00, h01, h10, h11, q;
      if (r.req_type == REQ_TIME) begin
         curve_times[r.key_index] = r.time_word;
         if (r.key_index == 0) curve_order_bad = 0;
         else if (r.time_word <= curve_times[r.key_index-1]) curve_order_bad = 1;
         return;
      end
      if (r.req_type == REQ_ENTRY) begin
         if (r.value_slot <= SLOT_OUT)
            curve_entries[(r.key_index*3 + r.value_slot)*KCS_MAX_COMPONENTS
                          + r.comp_index] = r.data_word;
         return;
      end
      if (r.req_type != REQ_SAMPLE) return;
      n = (cfg_keys == 0) ? 1 : (cfg_keys > KCS_MAX_KEYS ? KCS_MAX_KEYS : cfg_keys);
      nc = (cfg_comps == 0) ? 1 : (cfg_comps > KCS_MAX_COMPONENTS ?
                                   KCS_MAX_COMPONENTS : cfg_comps);
      mode = (cfg_mode == 2'd3) ? MODE_LINEAR : cfg_mode;
      if (mode == MODE_CUBIC && n < 2) begin
         push_result(0, 0, 1, STATUS_FEW_KEYS);
         return;
      end
      if (curve_order_bad) begin
         push_result(0, 0, 1, STATUS_ORDER);
         return;
      end
      if (n == 1 || r.time_word <= curve_times[0] || r.time_word >= curve_times[n-1]) begin
         kk = (n == 1 || r.time_word <= curve_times[0]) ? 0 : n - 1;
         for (int c = 0; c < nc; c++)
            push_result(c, saturate(entry_value(kk, SLOT_VALUE, c)), c + 1 == nc,
                        STATUS_OK);
         return;
      end
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (r.time_word < curve_times[mid]) hi = mid; else lo = mid;
      end
      k = lo;
      tk = curve_times[k];
      tk1 = curve_times[k+1];
      td = (tk1 > tk) ? tk1 - tk : 0;
      if (td == 0 || r.time_word < tk) w = 0;
      else if (r.time_word - tk >= td) w = 65535;
      else w = ({32'd0, r.time_word - tk} << 16) / {32'd0, td};
      for (int c = 0; c < nc; c++) begin
         a = entry_value(k, SLOT_VALUE, c);
         b = entry_value(k + 1, SLOT_VALUE, c);
         if (mode == MODE_STEP) v = a;
         else if (mode == MODE_LINEAR) v = a + floor16((b - a) * longint'(w));
         else begin
            t2 = (longint'(w) * longint'(w)) >> 16;
            t3 = (t2 * longint'(w)) >> 16;
            h00 = 2*t3 - 3*t2 + 65536;
            h01 = 3*t2 - 2*t3;
            h10 = t3 - 2*t2 + longint'(w);
            h11 = t3 - t2;
            q = floor16(h10 * entry_value(k, SLOT_OUT, c)
                        + h11 * entry_value(k + 1, SLOT_IN, c));
            v = floor16(h00*a + h01*b) + floor16(q * longint'(td));
         end
         push_result(c, saturate(v), c + 1 == nc, STATUS_OK);
      end
   endfunction

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         // Leave valid alone unless the current request was taken.
         if (pending_requests.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            request_type r;
            r = pending_requests.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.req_type <= r.req_type;
            req_bus.key_index <= r.key_index;
            req_bus.comp_index <= r.comp_index;
            req_bus.value_slot <= r.value_slot;
            req_bus.time_word <= r.time_word;
            req_bus.data_word <= r.data_word;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // The taken flag is sampled at the rising edge so the driver sees a stable value.
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         request_type r;
         r.req_type = req_bus.req_type;
         r.key_index = req_bus.key_index;
         r.comp_index = req_bus.comp_index;
         r.value_slot = req_bus.value_slot;
         r.time_word = req_bus.time_word;
         r.data_word = req_bus.data_word;
         predict_curve(r);
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sample_type got, want;
         got.out_component = rsp_bus.out_component;
         got.sample_value = rsp_bus.sample_value;
         got.last_component = rsp_bus.last_component;
         got.status = rsp_bus.status;
         if (expected_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result: comp %0d value %h last %0d status %0d",
                        got.out_component, got.sample_value, got.last_component,
                        got.status);
         end else begin
            want = expected_samples.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected comp %0d value %h last %0d status %0d, got comp %0d value %h last %0d status %0d",
                           want.out_component, want.sample_value, want.last_component,
                           want.status, got.out_component, got.sample_value,
                           got.last_component, got.status);
            end
         end
      end
   end

   task automatic write_csr(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr <= index;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         CSR_INTERP_MODE: cfg_mode = value[1:0];
         CSR_KEY_COUNT: cfg_keys = value[6:0];
         default: cfg_comps = value[2:0];
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic queue_request(logic [1:0] kind, int key, int comp, logic [1:0] slot,
                                logic [31:0] tw, logic [31:0] dw);
      request_type r;
      r.req_type = kind;
      r.key_index = key[5:0];
      r.comp_index = comp[1:0];
      r.value_slot = slot;
      r.time_word = tw;
      r.data_word = dw;
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_bus.valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Loads a strictly increasing grid of n keys with random entries for the components
   // in use; tangents are loaded only when the curve is cubic.
   task automatic load_curve(int n, int step_max, int ncomp, bit all_slots);
      logic [31:0] tw;
      tw = $urandom_range(1000);
      for (int k = 0; k < n; k++) begin
         queue_request(REQ_TIME, k, 0, SLOT_IN, tw, $urandom);
         for (int c = 0; c < ncomp; c++)
            for (int s = 0; s < 3; s++)
               if (all_slots || s == SLOT_VALUE)
                  queue_request(REQ_ENTRY, k, c, s[1:0], $urandom,
                                ($urandom_range(3) == 0) ? $urandom :
                                $urandom_range(2000000) - 1000000);
         tw = tw + 1 + $urandom_range(step_max);
      end
   endtask

   task automatic random_samples(int count, logic [31:0] span);
      for (int i = 0; i < count; i++)
         queue_request(($urandom_range(19) == 0) ? 2'd3 : REQ_SAMPLE, $urandom, $urandom,
                       $urandom, $urandom_range(span), $urandom);
   endtask

   initial begin
      int nkeys;
      int ncomp;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_TIME;
      req_bus.key_index = '0;
      req_bus.comp_index = '0;
      req_bus.value_slot = SLOT_IN;
      req_bus.time_word = '0;
      req_bus.data_word = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = CSR_INTERP_MODE;
      csr_bus.wdata = '0;
      send_idle_pct = 31;
      recv_idle_pct = 69;
      recv_hold = 0;
      req_taken = 0;
      mismatch_count = 0;
      curve_order_bad = 0;
      cfg_mode = MODE_LINEAR;
      cfg_keys = 1;
      cfg_comps = 1;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extreme values, a cubic status with one key, order error and recovery.
      queue_request(REQ_TIME, 0, 0, SLOT_IN, 32'h0, 0);
      queue_request(REQ_TIME, 1, 0, SLOT_IN, 32'hffffffff, 0);
      for (int k = 0; k < 2; k++)
         for (int s = 0; s < 3; s++)
            queue_request(REQ_ENTRY, k, 0, s[1:0], 0, k ? 32'h7fffffff : 32'h80000000);
      queue_request(REQ_ENTRY, 63, 3, SLOT_VALUE, 0, 32'h12345678);
      queue_request(REQ_ENTRY, 5, 1, 2'd3, 0, 32'hffffffff);
      queue_request(2'd3, 63, 3, 2'd3, 32'hffffffff, 32'hffffffff);
      queue_request(REQ_SAMPLE, 0, 0, SLOT_IN, 32'h5, 0);
      wait_drained();
      write_csr(CSR_INTERP_MODE, MODE_CUBIC);
      queue_request(REQ_SAMPLE, 0, 0, SLOT_IN, 32'h80000000, 0);
      wait_drained();
      write_csr(CSR_KEY_COUNT, 2);
      queue_request(REQ_SAMPLE, 0, 0, SLOT_IN, 32'h80000000, 0);
      queue_request(REQ_SAMPLE, 0, 0, SLOT_IN, 32'hffffffff, 0);
      queue_request(REQ_TIME, 1, 0, SLOT_IN, 32'h0, 0);
      queue_request(REQ_SAMPLE, 0, 0, SLOT_IN, 32'h1, 0);
      queue_request(REQ_TIME, 0, 0, SLOT_IN, 32'h0, 0);
      queue_request(REQ_TIME, 1, 0, SLOT_IN, 32'hffffffff, 0);
      queue_request(REQ_SAMPLE, 0, 0, SLOT_IN, 32'h7fffffff, 0);
      wait_drained();

      // Random phases across modes, key and component counts.
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 4) begin send_idle_pct = 69; recv_idle_pct = 31; end
         if (phase == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
         nkeys = (phase == 0) ? 64 : ((phase % 4 == 1) ? 1 : $urandom_range(2, 5));
         // The full grid carries one component so that the widest key count stays cheap.
         ncomp = (phase == 0 || phase == 9) ? 1 :
                 ((phase == 6) ? 0 : ((phase == 10) ? 7 : $urandom_range(1, 4)));
         write_csr(CSR_INTERP_MODE, phase % 4);
         write_csr(CSR_KEY_COUNT, (phase == 5) ? 0 : ((phase == 9) ? 100 : nkeys));
         write_csr(CSR_COMPONENT_COUNT, ncomp);
         load_curve(nkeys < 2 ? 2 : nkeys, (phase == 0) ? 3 : 500000,
                    (ncomp == 0) ? 1 : ((ncomp > 4) ? 4 : ncomp), phase % 4 == 2);
         if (phase == 7) queue_request(REQ_TIME, 1, 0, SLOT_IN, 0, 0);
         random_samples(9, (phase == 0) ? 1300 : 32'hffffffff);
         if (phase == 8) begin
            // Long receiver stall while requests keep coming.
            recv_hold = 1;
            repeat (600) @(posedge clock);
            recv_hold = 0;
         end
         wait_drained();
      end
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

### keyframe_curve_sampler_top.f
hdl/kcs_pkg.sv
hdl/kcs_if.sv
hdl/kcs_ram.sv
hdl/kcs_ctrl.sv
hdl/kcs_dp.sv
hdl/keyframe_curve_sampler_top.sv
bench/kcs_tb_if.sv
bench/tb.sv
